// File: rtl/core/nkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nkf_pkg
// Shared widths, codes and control structs of the NK-landscape fitness block.
// ----------------------------------------------------------------------------
package nkf_pkg;

   // field widths of the item channels
   localparam int OP_W       = 2;
   localparam int LOCUS_W    = 6;
   localparam int INDEX_W    = 8;
   localparam int VALUE_W    = 16;
   localparam int CHROM_W    = 64;
   localparam int FIT_W      = 22;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 24;

   // configuration register widths
   localparam int GENES_W    = 7;
   localparam int K_W        = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD_CONTRIB = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_NEIGH   = 2'd1;
   localparam logic [OP_W-1:0] OP_EVALUATE     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GENE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGH_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGH_MODE  = 2'd2;

   // effective (clamped) configuration
   typedef struct packed {
      logic [GENES_W-1:0] genes;
      logic [K_W-1:0]     k;
      logic               mode;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic               wr_contrib;
      logic               wr_neigh;
      logic               start;
      logic               rep_step;
      logic               issue;
      logic [LOCUS_W-1:0] issue_locus;
      logic               emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rep_done;
      logic busy;
   } stat_type;

endpackage

// File: rtl/core/nk_landscape_fitness.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nk_landscape_fitness
// NK-landscape fitness evaluator with loadable contribution and neighbor
// tables.
// ----------------------------------------------------------------------------
// Load items (contribution or neighbor entry) give no result. An evaluate item
// first runs R = ceil(log2(71 / N)) (one to seven) doubling steps, N being the
// gene count, that build a periodic image of the chromosome so that every gene
// position wraps modulo N without a divider. The locus loop then issues one
// locus per cycle: each locus reads its neighbor slots from per-slot memories,
// forms the index and reads one contribution entry from the single-port
// contribution memory, three stages deep, into a running sum. No new item is
// taken while an evaluation is under way. The result waits in an output
// register, so loads and the next evaluate are taken while it is still pending.
// Tables have no reset; an entry must be loaded before an evaluation reads it.
// ----------------------------------------------------------------------------
module nk_landscape_fitness #(
   parameter int MAX_GENES  = 64,
   parameter int MAX_K      = 7,
   parameter int VALUE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // locus[5:0], entry_index[13:6], entry_value[29:14], chromosome[93:30]
   input  logic [nkf_pkg::REQ_DATA_W-1:0]      req_tdata,
   // operation[1:0]
   input  logic [nkf_pkg::OP_W-1:0]            req_tuser,
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // fitness[21:0]
   output logic [nkf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration writes
   input  logic                                csr_we,
   input  logic [nkf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [nkf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import nkf_pkg::*;

   // configuration registers
   logic [GENES_W-1:0] gene_count_ff;
   logic [K_W-1:0]     neigh_count_ff;
   logic               neigh_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gene_count_ff  <= GENES_W'(64);
         neigh_count_ff <= K_W'(2);
         neigh_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GENE_COUNT:  gene_count_ff  <= csr_wdata[GENES_W-1:0];
            CSR_NEIGH_COUNT: neigh_count_ff <= csr_wdata[K_W-1:0];
            CSR_NEIGH_MODE:  neigh_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamp to the supported range
   cfg_type cfg;

   always_comb begin
      if (gene_count_ff == '0) begin
         cfg.genes = GENES_W'(1);
      end else if (gene_count_ff > GENES_W'(MAX_GENES)) begin
         cfg.genes = GENES_W'(MAX_GENES);
      end else begin
         cfg.genes = gene_count_ff;
      end
      cfg.k    = (neigh_count_ff > K_W'(MAX_K)) ? K_W'(MAX_K) : neigh_count_ff;
      cfg.mode = neigh_mode_ff;
   end

   // controller and datapath
   cmd_type          cmd;
   stat_type         stat;
   logic             req_ready;
   logic             rsp_free;
   logic [FIT_W-1:0] dp_fitness;
   logic             rsp_valid_ff;
   logic [FIT_W-1:0] rsp_fit_ff;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = req_ready;

   nkf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_ready),
      .cfg       (cfg),
      .stat      (stat),
      .rsp_free  (rsp_free),
      .cmd       (cmd)
   );

   nkf_datapath #(
      .MAX_GENES  (MAX_GENES),
      .MAX_K      (MAX_K),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .ld_locus   (req_tdata[5:0]),
      .ld_index   (req_tdata[13:6]),
      .ld_value   (req_tdata[29:14]),
      .chromosome (req_tdata[93:30]),
      .stat       (stat),
      .fitness    (dp_fitness)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_fit_ff <= dp_fitness;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_fit_ff);

endmodule

// File: rtl/core/nkf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nkf_ctrl
// Sequencer: decodes items, runs the chromosome replication, issues one locus
// per cycle, waits for the pipeline to drain and hands the sum to the output.
// ----------------------------------------------------------------------------
module nkf_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [nkf_pkg::OP_W-1:0]    req_op,
   output logic                        req_ready,
   input  nkf_pkg::cfg_type            cfg,
   input  nkf_pkg::stat_type           stat,
   input  logic                        rsp_free,
   output nkf_pkg::cmd_type            cmd
);
   import nkf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_BUILD = 5'b00010,
      ST_RUN   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [LOCUS_W-1:0] locus_ff, locus_in;
   logic               last_locus;

   assign last_locus = ({1'b0, locus_ff} == (cfg.genes - GENES_W'(1)));
   assign req_ready  = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      locus_in        = locus_ff;
      cmd             = '0;
      cmd.issue_locus = locus_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_LOAD_CONTRIB: cmd.wr_contrib = 1'b1;
                  OP_LOAD_NEIGH:   cmd.wr_neigh   = 1'b1;
                  OP_EVALUATE: begin
                     cmd.start = 1'b1;
                     state_in  = ST_BUILD;
                  end
                  default: ;
               endcase
            end
         end
         ST_BUILD: begin
            locus_in = '0;
            if (stat.rep_done) begin
               state_in = ST_RUN;
            end else begin
               cmd.rep_step = 1'b1;
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            locus_in  = locus_ff + LOCUS_W'(1);
            if (last_locus) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         locus_ff <= '0;
      end else begin
         state_ff <= state_in;
         locus_ff <= locus_in;
      end
   end

endmodule

// File: rtl/core/nkf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nkf_datapath
// Contribution and neighbor tables, periodic chromosome image, per-locus
// index formation and the fitness accumulator.
// ----------------------------------------------------------------------------
module nkf_datapath #(
   parameter int MAX_GENES  = 64,
   parameter int MAX_K      = 7,
   parameter int VALUE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  nkf_pkg::cmd_type               cmd,
   input  nkf_pkg::cfg_type               cfg,
   input  logic [nkf_pkg::LOCUS_W-1:0]    ld_locus,
   input  logic [nkf_pkg::INDEX_W-1:0]    ld_index,
   input  logic [nkf_pkg::VALUE_W-1:0]    ld_value,
   input  logic [nkf_pkg::CHROM_W-1:0]    chromosome,
   output nkf_pkg::stat_type              stat,
   output logic [nkf_pkg::FIT_W-1:0]      fitness
);
   import nkf_pkg::*;

   localparam int GB     = $clog2(MAX_GENES);
   localparam int IW     = MAX_K + 1;
   localparam int SPAN   = 1 << IW;
   localparam int CDEPTH = MAX_GENES * SPAN;
   localparam int SW     = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
   localparam int AW     = SW + GB;
   localparam int EXT_W  = CHROM_W + MAX_K;
   localparam int PW     = $clog2(EXT_W);
   localparam int SH_W   = PW + 1;

   // load address check
   logic ld_ok;
   assign ld_ok = ({1'b0, ld_locus} < (LOCUS_W + 1)'(MAX_GENES));

   // periodic chromosome image: ext[p] = chromosome[p mod N]
   logic [EXT_W-1:0]   ext_ff, ext_in;
   logic [SH_W-1:0]    shift_ff, shift_in;
   logic [CHROM_W-1:0] gene_mask;

   assign gene_mask = ~({CHROM_W{1'b1}} << cfg.genes);

   always_comb begin
      ext_in   = ext_ff;
      shift_in = shift_ff;
      if (cmd.start) begin
         ext_in   = EXT_W'(chromosome & gene_mask);
         shift_in = SH_W'(cfg.genes);
      end else if (cmd.rep_step) begin
         ext_in   = ext_ff | (ext_ff << shift_ff);
         shift_in = shift_ff << 1;
      end
   end

   always_ff @(posedge clock) begin
      ext_ff   <= ext_in;
      shift_ff <= shift_in;
   end

   assign stat.rep_done = (shift_ff >= SH_W'(EXT_W));

   // neighbor table: one memory per slot, addressed by locus
   logic [LOCUS_W-1:0] nbr_rd [MAX_K];

   for (genvar j = 0; j < MAX_K; j++) begin : g_slot
      logic [LOCUS_W-1:0] nbr_mem [MAX_GENES];
      logic               slot_wr;

      assign slot_wr = cmd.wr_neigh && ld_ok && (ld_index == INDEX_W'(j));

      always_ff @(posedge clock) begin
         if (slot_wr) begin
            nbr_mem[ld_locus[GB-1:0]] <= ld_value[LOCUS_W-1:0];
         end
         if (cmd.issue) begin
            nbr_rd[j] <= nbr_mem[cmd.issue_locus[GB-1:0]];
         end
      end
   end

   // stage A: neighbor read under way
   logic          a_valid_ff;
   logic [GB-1:0] a_locus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= cmd.issue;
      end
      a_locus_ff <= cmd.issue_locus[GB-1:0];
   end

   // stage B: gather gene bits and form the table index
   logic [IW-1:0] idx_full;
   logic [IW-1:0] idx;

   always_comb begin
      idx_full[MAX_K] = ext_ff[PW'(a_locus_ff)];
      for (int j = 0; j < MAX_K; j++) begin
         if (cfg.mode) begin
            idx_full[MAX_K-1-j] = ext_ff[PW'(a_locus_ff) + PW'(j) + PW'(1)];
         end else begin
            idx_full[MAX_K-1-j] = ext_ff[PW'(nbr_rd[j])];
         end
      end
      idx = idx_full >> (K_W'(MAX_K) - cfg.k);
   end

   // contribution table, row per locus
   logic [SW-1:0] cont_mem [CDEPTH];
   logic [SW-1:0] cont_rd_ff;
   logic          b_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_contrib && ld_ok) begin
         cont_mem[{ld_locus[GB-1:0], ld_index[IW-1:0]}] <= ld_value[SW-1:0];
      end
      if (a_valid_ff) begin
         cont_rd_ff <= cont_mem[{a_locus_ff, idx}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   assign stat.busy = a_valid_ff | b_valid_ff;

   // stage C: accumulate
   logic [AW-1:0] acc_ff, acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (b_valid_ff) begin
         acc_in = acc_ff + AW'(cont_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // saturate to the result field where the sum is wider than it
   if (AW > FIT_W) begin : g_sat
      assign fitness = (|acc_ff[AW-1:FIT_W]) ? {FIT_W{1'b1}} : acc_ff[FIT_W-1:0];
   end else begin : g_nosat
      assign fitness = FIT_W'(acc_ff);
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NK-landscape fitness evaluator. Each directed
// and random test drives load and evaluate items into the request stream
// while a local score model tracks both tables and the registers. Every
// fitness returned on the response stream is checked against that model.
// Both stream sides idle at random, and one test holds the response side off
// for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;
   import nkf_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 400;
   localparam int GENES_MAX    = 64;
   localparam int K_MAX        = 7;
   localparam int SPAN         = 256;

   // codes the package leaves undefined
   localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // score model state
   logic [VALUE_W-1:0] contrib_mem [GENES_MAX][SPAN];
   bit                 contrib_set [GENES_MAX][SPAN];
   logic [LOCUS_W-1:0] neigh_mem   [GENES_MAX][K_MAX];
   bit                 neigh_set   [GENES_MAX][K_MAX];
   logic [GENES_W-1:0] cfg_genes = 7'd64;
   logic [K_W-1:0]     cfg_k     = 3'd2;
   logic               cfg_mode  = 1'b0;

   logic [FIT_W-1:0] fitness_due [$];

   int  items_sent;
   int  n_evals;
   int  n_loads;
   int  n_ignored;
   int  n_results;
   int  n_settings;
   int  errors;
   int  cycle_count;
   bit  no_idle;
   bit  hold_req;
   int  hold_left;
   int  run_left;
   logic [CHROM_W-1:0] chrom_walk;

   nk_landscape_fitness i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // score model
   // ---------------------------------------------------------------------
   function automatic int genes_used();
      if (cfg_genes == 0) return 1;
      if (cfg_genes > GENES_MAX) return GENES_MAX;
      return int'(cfg_genes);
   endfunction

   // table index of one locus: own gene on top, then K neighbor genes
   function automatic logic [7:0] locus_index(logic [CHROM_W-1:0] chrom, int i);
      int         n;
      int         pos;
      logic [7:0] idx;
      n   = genes_used();
      idx = {7'd0, chrom[i]};
      for (int j = 0; j < int'(cfg_k); j++) begin
         pos = cfg_mode ? (i + 1 + j) : int'(neigh_mem[i][j]);
         idx = {idx[6:0], chrom[pos % n]};
      end
      return idx;
   endfunction

   function automatic logic [FIT_W-1:0] score_chrom(logic [CHROM_W-1:0] chrom);
      longint unsigned total;
      total = 0;
      for (int i = 0; i < genes_used(); i++)
         total += contrib_mem[i][locus_index(chrom, i)];
      if (total > 64'h3F_FFFF) total = 64'h3F_FFFF;
      return total[FIT_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CHROM_W-1:0] rand_chrom();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return VALUE_W'($urandom);
   endfunction

   // one item on the request stream; model updated at the accepting edge
   task automatic send_item(logic [OP_W-1:0] op, logic [LOCUS_W-1:0] locus,
                            logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val,
                            logic [CHROM_W-1:0] chrom);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, chrom, val, idx, locus};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_LOAD_CONTRIB: begin
            contrib_mem[locus][idx] = val;
            contrib_set[locus][idx] = 1'b1;
            n_loads++;
            items_sent++;
         end
         OP_LOAD_NEIGH: begin
            if (idx < K_MAX) begin
               neigh_mem[locus][idx] = val[LOCUS_W-1:0];
               neigh_set[locus][idx] = 1'b1;
               n_loads++;
               items_sent++;
            end else begin
               n_ignored++;
            end
         end
         OP_EVALUATE: begin
            fitness_due.push_back(score_chrom(chrom));
            n_evals++;
            items_sent++;
         end
         default: n_ignored++;
      endcase
   endtask

   // loads each table entry the chromosome will read that is still unset, then evaluates it
   task automatic evaluate_chrom(logic [CHROM_W-1:0] chrom);
      logic [7:0] idx;
      for (int i = 0; i < genes_used(); i++)
         for (int j = 0; j < int'(cfg_k); j++)
            if (!neigh_set[i][j])
               send_item(OP_LOAD_NEIGH, LOCUS_W'(i), INDEX_W'(j), VALUE_W'($urandom),
                         rand_chrom());
      for (int i = 0; i < genes_used(); i++) begin
         idx = locus_index(chrom, i);
         if (!contrib_set[i][idx])
            send_item(OP_LOAD_CONTRIB, LOCUS_W'(i), idx, rand_value(), rand_chrom());
      end
      send_item(OP_EVALUATE, LOCUS_W'($urandom), INDEX_W'($urandom), VALUE_W'($urandom),
                chrom);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (fitness_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_GENE_COUNT:  cfg_genes = data;
         CSR_NEIGH_COUNT: cfg_k     = data[K_W-1:0];
         CSR_NEIGH_MODE:  cfg_mode  = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // upper write bits of the narrow registers carry random junk
   task automatic configure(logic [GENES_W-1:0] genes, logic [K_W-1:0] k, bit mode);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      wait_idle();
      write_reg(CSR_GENE_COUNT, genes);
      write_reg(CSR_NEIGH_COUNT, {junk[6:3], k});
      write_reg(CSR_NEIGH_MODE, {junk[6:1], mode});
      n_settings++;
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // registers as they come out of reset
   task automatic test_reset_config();
      evaluate_chrom('0);
      evaluate_chrom('1);
      evaluate_chrom(64'hA5A5_5A5A_0F0F_F0F0);
   endtask

   // widest index, extreme values, ignored loads and the unused code
   task automatic test_load_corners();
      configure(7'd64, 3'd7, 1'b1);
      send_item(OP_LOAD_CONTRIB, 6'd63, 8'd255, 16'hFFFF, rand_chrom());
      send_item(OP_LOAD_CONTRIB, 6'd0, 8'd0, 16'h0000, rand_chrom());
      send_item(OP_LOAD_NEIGH, 6'd5, 8'd7, VALUE_W'($urandom), rand_chrom());
      send_item(OP_LOAD_NEIGH, 6'd5, 8'd255, VALUE_W'($urandom), rand_chrom());
      send_item(OP_UNUSED, LOCUS_W'($urandom), INDEX_W'($urandom), VALUE_W'($urandom),
                rand_chrom());
      evaluate_chrom('1);
      evaluate_chrom('0);
      configure(7'd64, 3'd7, 1'b0);
      send_item(OP_LOAD_NEIGH, 6'd63, 8'd6, 16'hFFFF, rand_chrom());
      send_item(OP_LOAD_NEIGH, 6'd0, 8'd0, 16'hFFC0, rand_chrom());
      evaluate_chrom('1);
      evaluate_chrom(64'h8000_0000_0000_0001);
   endtask

   // every locus at full contribution, then every locus at zero
   task automatic test_full_scale();
      configure(7'd64, 3'd0, 1'b1);
      for (int i = 0; i < GENES_MAX; i++) begin
         send_item(OP_LOAD_CONTRIB, LOCUS_W'(i), 8'd1, 16'hFFFF, rand_chrom());
         send_item(OP_LOAD_CONTRIB, LOCUS_W'(i), 8'd0, 16'h0000, rand_chrom());
      end
      evaluate_chrom('1);
      evaluate_chrom('0);
      evaluate_chrom(rand_chrom());
   endtask

   // tiny and clamped gene counts, epistasis at or above the gene count
   task automatic test_small_genes();
      configure(7'd1, 3'd0, 1'b0);
      evaluate_chrom('1);
      evaluate_chrom(64'hFFFF_FFFF_FFFF_FFFE);
      configure(7'd0, 3'd7, 1'b1);
      evaluate_chrom(rand_chrom());
      evaluate_chrom(64'h1);
      configure(7'd3, 3'd7, 1'b0);
      for (int i = 0; i < 4; i++) evaluate_chrom(rand_chrom());
      configure(7'd2, 3'd1, 1'b1);
      for (int i = 0; i < 4; i++) evaluate_chrom(rand_chrom());
      configure(7'd127, 3'd7, 1'b0);
      evaluate_chrom(rand_chrom());
      // the unused register index changes nothing
      wait_idle();
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      evaluate_chrom(rand_chrom());
   endtask

   // response side held off while requests keep coming
   task automatic test_backpressure();
      configure(7'd8, 3'd3, 1'b0);
      no_idle  = 1'b1;
      hold_req = 1'b1;
      for (int i = 0; i < 24; i++) begin
         if (i % 3 == 2)
            send_item(OP_LOAD_CONTRIB, LOCUS_W'($urandom), INDEX_W'($urandom),
                      rand_value(), rand_chrom());
         else
            evaluate_chrom(rand_chrom());
      end
      no_idle = 1'b0;
   endtask

   // mostly evaluations of a mutating chromosome, mixed with loads and noise
   task automatic run_random_phase(int count);
      int start;
      int r;
      start      = items_sent;
      chrom_walk = rand_chrom();
      while (items_sent - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            repeat ($urandom_range(1, 3)) chrom_walk[$urandom_range(0, 63)] ^= 1'b1;
            evaluate_chrom(chrom_walk);
         end else if (r < 58) begin
            evaluate_chrom(rand_chrom());
         end else if (r < 78) begin
            send_item(OP_LOAD_CONTRIB, LOCUS_W'($urandom), INDEX_W'($urandom),
                      rand_value(), rand_chrom());
         end else if (r < 92) begin
            send_item(OP_LOAD_NEIGH, LOCUS_W'($urandom), INDEX_W'($urandom_range(0, 6)),
                      VALUE_W'($urandom), rand_chrom());
         end else if (r < 96) begin
            send_item(OP_LOAD_NEIGH, LOCUS_W'($urandom), INDEX_W'($urandom),
                      VALUE_W'($urandom), rand_chrom());
         end else begin
            send_item(OP_UNUSED, LOCUS_W'($urandom), INDEX_W'($urandom),
                      VALUE_W'($urandom), rand_chrom());
         end
      end
   endtask

   task automatic test_random_phases();
      configure(7'd64, 3'd7, 1'b0);
      run_random_phase(30);
      configure(7'd64, 3'd7, 1'b1);
      run_random_phase(30);
      configure(7'd1, 3'd0, 1'b0);
      run_random_phase(20);
      configure(7'd0, 3'd7, 1'b1);
      run_random_phase(20);
      configure(7'd127, 3'd5, 1'b0);
      run_random_phase(30);
      configure(7'd3, 3'd7, 1'b0);
      run_random_phase(20);
      // back-to-back stretch on both sides
      configure(7'd17, 3'd3, 1'b1);
      no_idle = 1'b1;
      run_random_phase(30);
      no_idle = 1'b0;
      configure(7'd64, 3'd0, 1'b0);
      run_random_phase(20);
      for (int p = 0; p < 2; p++) begin
         configure(GENES_W'($urandom_range(0, 127)), K_W'($urandom), 1'($urandom));
         run_random_phase(20);
      end
   endtask

   // ---------------------------------------------------------------------
   // response side: random idling plus the long hold-off
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_sink
      int len;
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (run_left > 0) begin
         run_left--;
      end else if (no_idle || $urandom_range(0, 99) < 60) begin
         rsp_tready <= 1'b1;
         run_left = $urandom_range(0, 15);
      end else begin
         len = pick_gap();
         rsp_tready <= (len == 0);
         run_left = (len == 0) ? 0 : len - 1;
      end
   end

   // result check against the oldest expected fitness
   always @(posedge clock) begin : fitness_check
      logic [FIT_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (fitness_due.size() == 0) begin
            if (errors < 10)
               $display("unexpected result 0x%06h at cycle %0d", rsp_tdata, cycle_count);
            errors++;
         end else begin
            want = fitness_due.pop_front();
            if (rsp_tdata !== {{(RSP_DATA_W-FIT_W){1'b0}}, want}) begin
               if (errors < 10)
                  $display("fitness mismatch at cycle %0d: expected 0x%06h got 0x%06h",
                           cycle_count, want, rsp_tdata);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, fitness_due.size());
         $display("nk_landscape_fitness test failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_load_corners();
      test_full_scale();
      test_small_genes();
      test_backpressure();
      test_random_phases();
      wait_idle();
      $display("ran %0d items: %0d evaluations, %0d table loads, %0d ignored, %0d settings",
               items_sent, n_evals, n_loads, n_ignored, n_settings);
      $display("checked %0d fitness results in %0d cycles, %0d failures",
               n_results, cycle_count, errors);
      if (errors == 0) begin
         $display("nk_landscape_fitness test passed");
      end else begin
         $display("nk_landscape_fitness test failed");
      end
      $finish;
   end

endmodule
